// ----- rtl/lca_pkg.sv -----
// shared types, constants and helpers of the 3d life automaton
`timescale 1ns / 1ps

package lca_pkg;

   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int MAX_LAYERS = 16;

   localparam int ROW_W  = 4;
   localparam int COL_W  = 4;
   localparam int LAY_W  = 4;
   localparam int DIM_W  = 5;
   localparam int ADDR_W = LAY_W + ROW_W;
   localparam int WORDS  = 1 << ADDR_W;
   localparam int CNT_W  = 5;
   localparam int NB_W   = 4;

   localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] LAYS_LIM = DIM_W'(MAX_LAYERS);

   localparam logic [NB_W-1:0] NB_CENTRE = NB_W'(4);
   localparam logic [NB_W-1:0] NB_LAST   = NB_W'(8);

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_HEIGHT = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_DEPTH  = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_type;

   typedef logic [MAX_COLS-1:0] word_type;

   typedef struct packed {
      logic clr;
      logic acc;
      logic ctr;
   } gen_ctl_type;

   // layer offset (plus one) of neighbour slot nb
   function automatic logic [1:0] nb_dlay(input logic [NB_W-1:0] nb);
      logic [1:0] r;
      case (nb)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   // row offset (plus one) of neighbour slot nb
   function automatic logic [1:0] nb_drow(input logic [NB_W-1:0] nb);
      logic [1:0] r;
      case (nb)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      return (v > lim) ? lim : v;
   endfunction

endpackage

// ----- rtl/lca_store.sv -----
// cell store: current generation and scratch generation, one row word per entry
`timescale 1ns / 1ps

module lca_store (
   input  logic                      clock,
   input  logic                      now_rd_en,
   input  logic [lca_pkg::ADDR_W-1:0] now_rd_addr,
   output lca_pkg::word_type         now_rd_data,
   input  logic                      now_wr_en,
   input  logic [lca_pkg::ADDR_W-1:0] now_wr_addr,
   input  lca_pkg::word_type         now_wr_data,
   input  logic                      nxt_rd_en,
   input  logic [lca_pkg::ADDR_W-1:0] nxt_rd_addr,
   output lca_pkg::word_type         nxt_rd_data,
   input  logic                      nxt_wr_en,
   input  logic [lca_pkg::ADDR_W-1:0] nxt_wr_addr,
   input  lca_pkg::word_type         nxt_wr_data
);
   import lca_pkg::*;

   word_type now_mem [WORDS];
   word_type nxt_mem [WORDS];
   word_type now_q_ff;
   word_type nxt_q_ff;

   always_ff @(posedge clock) begin
      if (now_wr_en) begin
         now_mem[now_wr_addr] <= now_wr_data;
      end
      if (now_rd_en) begin
         now_q_ff <= now_mem[now_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (nxt_wr_en) begin
         nxt_mem[nxt_wr_addr] <= nxt_wr_data;
      end
      if (nxt_rd_en) begin
         nxt_q_ff <= nxt_mem[nxt_rd_addr];
      end
   end

   assign now_rd_data = now_q_ff;
   assign nxt_rd_data = nxt_q_ff;

endmodule

// ----- rtl/lca_gen.sv -----
// per-column neighbour accumulators and next-state rule for one row word
`timescale 1ns / 1ps

module lca_gen (
   input  logic                     clock,
   input  lca_pkg::gen_ctl_type     ctl,
   input  lca_pkg::word_type        data,
   input  logic [lca_pkg::DIM_W-1:0] wid,
   input  logic                     flat,
   output lca_pkg::word_type        next_word
);
   import lca_pkg::*;

   logic [CNT_W-1:0] sum_ff [MAX_COLS];
   logic [CNT_W-1:0] sum_in [MAX_COLS];
   word_type         ctr_ff;
   word_type         ctr_in;
   word_type         mask;
   word_type         mdata;

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         mask[c] = (DIM_W'(c) < wid);
      end
      mdata = data & mask;
   end

   always_comb begin
      logic lo;
      logic hi;
      lo = 1'b0;
      hi = 1'b0;
      ctr_in = ctl.ctr ? data : ctr_ff;
      for (int c = 0; c < MAX_COLS; c++) begin
         lo = (c > 0) ? mdata[(c > 0) ? c - 1 : 0] : 1'b0;
         hi = (c < MAX_COLS - 1) ? mdata[(c < MAX_COLS - 1) ? c + 1 : c] : 1'b0;
         if (ctl.clr) begin
            sum_in[c] = '0;
         end else if (ctl.acc) begin
            sum_in[c] = sum_ff[c] + CNT_W'(lo) + CNT_W'(mdata[c]) + CNT_W'(hi);
         end else begin
            sum_in[c] = sum_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      ctr_ff <= ctr_in;
   end

   // own cell was counted in the window, take it back out
   always_comb begin
      logic [CNT_W-1:0] n;
      logic             nb;
      n  = '0;
      nb = 1'b0;
      for (int c = 0; c < MAX_COLS; c++) begin
         n = sum_ff[c] - CNT_W'(ctr_ff[c] & mask[c]);
         if (flat) begin
            nb = ctr_ff[c] ? (n == CNT_W'(2) || n == CNT_W'(3)) : (n == CNT_W'(3));
         end else begin
            nb = ctr_ff[c] ? (n == CNT_W'(6)) : (n >= CNT_W'(5) && n <= CNT_W'(8));
         end
         next_word[c] = mask[c] ? nb : ctr_ff[c];
      end
   end

endmodule

// ----- rtl/life_automaton_3d_step.sv -----
// top level of the 3d life automaton: command sequencer around the cell store
`timescale 1ns / 1ps

// The grid lives in two 256 x 16 bit synchronous memories, one word per
// (layer, row) holding all sixteen columns. After reset the block clears
// the current generation and takes no transaction in that time
// (configuration writes are taken throughout). A write of a cell is one
// read-modify-write of its row word, a read one read of it; an out of
// range one or an unused command goes straight to its result. An advance
// visits every (layer, row) of the grid in use: nine neighbour row slots
// on the current generation's read port, outside rows skipped, then the
// ST_ADV_LAST and ST_ADV_WR states finish and write the scratch word; then
// a copy pass follows at one row per cycle. The read port limits the speed
// of the advance. One result per transaction; a new transaction is taken
// while the previous result still waits on rsp_stall.

module life_automaton_3d_step (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lca_pkg::cmd_type          req_cmd,
   input  logic [lca_pkg::ROW_W-1:0] req_row,
   input  logic [lca_pkg::COL_W-1:0] req_col,
   input  logic [lca_pkg::LAY_W-1:0] req_layer,
   input  logic                      req_alive_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_alive_out,
   output logic                      rsp_out_of_range,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  lca_pkg::csr_type          csr_index,
   input  logic [lca_pkg::DIM_W-1:0] csr_data
);
   import lca_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_ACC      = 9'b000000100,
      ST_ADV_RD   = 9'b000001000,
      ST_ADV_LAST = 9'b000010000,
      ST_ADV_WR   = 9'b000100000,
      ST_COPY     = 9'b001000000,
      ST_COPY_END = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;

   // configuration registers
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] depth_ff, depth_in;

   // latched transaction
   cmd_type          cmd_ff, cmd_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LAY_W-1:0] lay_ff, lay_in;
   logic             val_ff, val_in;

   // sweep counters, also used for the clearing pass
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [NB_W-1:0]   nb_ff, nb_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rd_ctr_ff, rd_ctr_in;
   logic              cp_ok_ff, cp_ok_in;
   logic [ADDR_W-1:0] cp_addr_ff, cp_addr_in;

   // pending result and output register
   logic             res_alive_ff, res_alive_in;
   logic             res_oor_ff, res_oor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_alive_ff, rsp_alive_in;
   logic             rsp_oor_ff, rsp_oor_in;

   // store ports
   logic              now_rd_en, now_wr_en, nxt_rd_en, nxt_wr_en;
   logic [ADDR_W-1:0] now_rd_addr, now_wr_addr, nxt_rd_addr, nxt_wr_addr;
   word_type          now_rd_data, now_wr_data, nxt_rd_data, nxt_wr_data;

   gen_ctl_type      gctl;
   word_type         gen_word;

   logic [DIM_W-1:0] h, w, d;
   logic             flat;
   logic             req_take;
   logic             in_grid;
   logic [DIM_W-1:0] tl, tr;
   logic             nb_ok;
   logic             last_row;

   lca_store u_store (
      .clock       (clock),
      .now_rd_en   (now_rd_en),
      .now_rd_addr (now_rd_addr),
      .now_rd_data (now_rd_data),
      .now_wr_en   (now_wr_en),
      .now_wr_addr (now_wr_addr),
      .now_wr_data (now_wr_data),
      .nxt_rd_en   (nxt_rd_en),
      .nxt_rd_addr (nxt_rd_addr),
      .nxt_rd_data (nxt_rd_data),
      .nxt_wr_en   (nxt_wr_en),
      .nxt_wr_addr (nxt_wr_addr),
      .nxt_wr_data (nxt_wr_data)
   );

   lca_gen u_gen (
      .clock     (clock),
      .ctl       (gctl),
      .data      (now_rd_data),
      .wid       (w),
      .flat      (flat),
      .next_word (gen_word)
   );

   // grid in use, sizes saturate at the store dimensions
   assign h    = clamp_dim(height_ff, ROWS_LIM);
   assign w    = clamp_dim(width_ff, COLS_LIM);
   assign d    = clamp_dim(depth_ff, LAYS_LIM);
   assign flat = (depth_ff <= DIM_W'(1));

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alive_out    = rsp_alive_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   assign in_grid = ({1'b0, req_row} < h) && ({1'b0, req_col} < w)
                    && ({1'b0, req_layer} < d);

   // neighbour coordinates plus one, zero or above the size means outside
   assign tl    = {1'b0, lay_ff} + DIM_W'(nb_dlay(nb_ff));
   assign tr    = {1'b0, row_ff} + DIM_W'(nb_drow(nb_ff));
   assign nb_ok = (tl != '0) && (tl <= d) && (tr != '0) && (tr <= h);

   assign last_row = ({1'b0, row_ff} == h - DIM_W'(1))
                     && ({1'b0, lay_ff} == d - DIM_W'(1));

   // accumulators clear between rows, count every returned neighbour word
   assign gctl.clr = (state_ff == ST_IDLE) || (state_ff == ST_ADV_WR);
   assign gctl.acc = rd_ok_ff;
   assign gctl.ctr = rd_ctr_ff;

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      depth_in  = depth_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEIGHT: height_in = csr_data;
            CSR_WIDTH:  width_in  = csr_data;
            CSR_DEPTH:  depth_in  = csr_data;
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      lay_in       = lay_ff;
      val_in       = val_ff;
      clr_in       = clr_ff;
      nb_in        = nb_ff;
      rd_ok_in     = 1'b0;
      rd_ctr_in    = 1'b0;
      cp_ok_in     = 1'b0;
      cp_addr_in   = cp_addr_ff;
      res_alive_in = res_alive_ff;
      res_oor_in   = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_alive_in = rsp_alive_ff;
      rsp_oor_in   = rsp_oor_ff;

      now_rd_en   = 1'b0;
      now_rd_addr = {lay_ff, row_ff};
      now_wr_en   = 1'b0;
      now_wr_addr = {lay_ff, row_ff};
      now_wr_data = now_rd_data;
      nxt_rd_en   = 1'b0;
      nxt_rd_addr = {lay_ff, row_ff};
      nxt_wr_en   = 1'b0;
      nxt_wr_addr = {lay_ff, row_ff};
      nxt_wr_data = gen_word;

      // copy pass write lands in the cycle after its read
      if (cp_ok_ff) begin
         now_wr_en   = 1'b1;
         now_wr_addr = cp_addr_ff;
         now_wr_data = nxt_rd_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            now_wr_en   = 1'b1;
            now_wr_addr = clr_ff;
            now_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in       = req_cmd;
               col_in       = req_col;
               val_in       = req_alive_in;
               res_alive_in = 1'b0;
               res_oor_in   = 1'b0;
               nb_in        = '0;
               case (req_cmd)
                  CMD_WRITE, CMD_READ: begin
                     row_in = req_row;
                     lay_in = req_layer;
                     if (in_grid) begin
                        now_rd_en   = 1'b1;
                        now_rd_addr = {req_layer, req_row};
                        state_in    = ST_ACC;
                     end else begin
                        res_oor_in = 1'b1;
                        state_in   = ST_DONE;
                     end
                  end
                  CMD_ADVANCE: begin
                     row_in = '0;
                     lay_in = '0;
                     // empty grid changes nothing
                     if (h == '0 || d == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_ADV_RD;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ACC: begin
            // row word of the addressed cell is back from the store
            if (cmd_ff == CMD_WRITE) begin
               now_wr_en           = 1'b1;
               now_wr_addr         = {lay_ff, row_ff};
               now_wr_data         = now_rd_data;
               now_wr_data[col_ff] = val_ff;
            end else begin
               res_alive_in = now_rd_data[col_ff];
            end
            state_in = ST_DONE;
         end
         ST_ADV_RD: begin
            // one neighbour row word per cycle, outside rows are skipped
            now_rd_en   = nb_ok;
            now_rd_addr = {LAY_W'(tl - DIM_W'(1)), ROW_W'(tr - DIM_W'(1))};
            rd_ok_in    = nb_ok;
            rd_ctr_in   = (nb_ff == NB_CENTRE);
            nb_in       = nb_ff + NB_W'(1);
            if (nb_ff == NB_LAST) begin
               state_in = ST_ADV_LAST;
            end
         end
         ST_ADV_LAST: begin
            state_in = ST_ADV_WR;
         end
         ST_ADV_WR: begin
            nxt_wr_en = 1'b1;
            nb_in     = '0;
            if (last_row) begin
               row_in   = '0;
               lay_in   = '0;
               state_in = ST_COPY;
            end else begin
               state_in = ST_ADV_RD;
               if ({1'b0, row_ff} == h - DIM_W'(1)) begin
                  row_in = '0;
                  lay_in = lay_ff + LAY_W'(1);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         ST_COPY: begin
            nxt_rd_en  = 1'b1;
            cp_ok_in   = 1'b1;
            cp_addr_in = {lay_ff, row_ff};
            if (last_row) begin
               state_in = ST_COPY_END;
            end else if ({1'b0, row_ff} == h - DIM_W'(1)) begin
               row_in = '0;
               lay_in = lay_ff + LAY_W'(1);
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_COPY_END: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         height_ff    <= ROWS_LIM;
         width_ff     <= COLS_LIM;
         depth_ff     <= DIM_W'(1);
         clr_ff       <= '0;
         nb_ff        <= '0;
         rd_ok_ff     <= 1'b0;
         rd_ctr_ff    <= 1'b0;
         cp_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         depth_ff     <= depth_in;
         clr_ff       <= clr_in;
         nb_ff        <= nb_in;
         rd_ok_ff     <= rd_ok_in;
         rd_ctr_ff    <= rd_ctr_in;
         cp_ok_ff     <= cp_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      lay_ff       <= lay_in;
      val_ff       <= val_in;
      cp_addr_ff   <= cp_addr_in;
      res_alive_ff <= res_alive_in;
      res_oor_ff   <= res_oor_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

endmodule
